/* rtl/fpd_pkg.sv */
package fpd_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DELTA_W     = COORD_W - FRAC_BITS;
    localparam int MAG_W       = DELTA_W + 1;
    localparam int SUM_W       = 32;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 1;
    localparam int SQRT_STAGES = ROOT_W;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SUM_W-1:0]  rad;
    } fpd_sqrt_t;

endpackage

/* rtl/fpd_axis.sv */
module fpd_axis
(
    input  logic                                clk,
    input  logic signed [fpd_pkg::COORD_W-1:0] first,
    input  logic signed [fpd_pkg::COORD_W-1:0] second,
    output logic        [fpd_pkg::SUM_W-1:0]   square
);
    import fpd_pkg::*;

    logic [COORD_W-1:0]   diff;
    logic [DELTA_W-1:0]   delta;
    logic [MAG_W-1:0]     mag_next;
    logic [MAG_W-1:0]     mag_reg;
    logic [2*MAG_W-1:0]   product;
    logic [SUM_W-1:0]     square_next;
    logic [SUM_W-1:0]     square_reg;

    // The integer part of the wrapped difference, taken as a magnitude.
    always_comb
    begin
        diff  = COORD_W'(first) - COORD_W'(second);
        delta = diff[COORD_W-1 -: DELTA_W];
        if (delta[DELTA_W-1])
        begin
            mag_next = (MAG_W'(1) << DELTA_W) - {1'b0, delta};
        end
        else
        begin
            mag_next = {1'b0, delta};
        end
    end

    always_comb
    begin
        product     = mag_reg * mag_reg;
        square_next = product[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        square_reg <= square_next;
    end

    assign square = square_reg;

endmodule

/* rtl/fpd_sqrt_cell.sv */
module fpd_sqrt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fpd_pkg::fpd_sqrt_t in_data,
    output logic               out_valid,
    output fpd_pkg::fpd_sqrt_t out_data
);
    import fpd_pkg::*;

    logic               valid_reg;
    fpd_sqrt_t          data_reg;
    fpd_sqrt_t          data_next;
    logic [REM_W+1:0]   cand;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   diff;
    logic               take;

    // One result bit per cell: bring down the next two radicand bits and
    // subtract the trial value when it fits.
    always_comb
    begin
        cand  = {in_data.rem, in_data.rad[SUM_W-1 -: 2]};
        trial = {1'b0, in_data.root, 2'b01};
        take  = (cand >= trial);
        diff  = cand - trial;
        data_next.rem  = take ? diff[REM_W-1:0] : cand[REM_W-1:0];
        data_next.root = {in_data.root[ROOT_W-2:0], take};
        data_next.rad  = {in_data.rad[SUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // The partial remainder never exceeds twice the partial root.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, data_reg.rem} <= {data_reg.root, 1'b0}))
        else $error("square root remainder out of range");

endmodule

/* rtl/fixed_point_3d_distance_core.sv */
// Pipeline: a taken beat passes a register for the axis deltas, one for the squares,
// one for the sum and sixteen square root cells before distance and done appear.
// Throughput: one beat per cycle; busy stays low, as every stage moves on each cycle.
// The receiver cannot stall, so done is a single cycle strobe with no hold-off.
// Reset is asynchronous and active low; it clears the valid flags of every stage only.
module fixed_point_3d_distance_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fpd_pkg::COORD_W-1:0] first_x,
    input  logic signed [fpd_pkg::COORD_W-1:0] first_y,
    input  logic signed [fpd_pkg::COORD_W-1:0] first_z,
    input  logic signed [fpd_pkg::COORD_W-1:0] second_x,
    input  logic signed [fpd_pkg::COORD_W-1:0] second_y,
    input  logic signed [fpd_pkg::COORD_W-1:0] second_z,
    output logic                                done,
    output logic        [fpd_pkg::ROOT_W-1:0]  distance
);
    import fpd_pkg::*;

    logic              accept;
    logic              mag_valid_reg;
    logic              sq_valid_reg;
    logic              sum_valid_reg;
    logic [SUM_W-1:0]  sq_x;
    logic [SUM_W-1:0]  sq_y;
    logic [SUM_W-1:0]  sq_z;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic              cell_valid [0:SQRT_STAGES];
    fpd_sqrt_t         cell_data  [0:SQRT_STAGES];
    logic [2*ROOT_W:0] root_sq;
    logic [2*ROOT_W:0] root_inc_sq;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    fpd_axis u_axis_x
    (
        .clk    (clk),
        .first  (first_x),
        .second (second_x),
        .square (sq_x)
    );

    fpd_axis u_axis_y
    (
        .clk    (clk),
        .first  (first_y),
        .second (second_y),
        .square (sq_y)
    );

    fpd_axis u_axis_z
    (
        .clk    (clk),
        .first  (first_z),
        .second (second_z),
        .square (sq_z)
    );

    // Each square is at most 2^30, so the sum of three fits without wrapping.
    assign sum_next = sq_x + sq_y + sq_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            mag_valid_reg <= accept;
            sq_valid_reg  <= mag_valid_reg;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign cell_valid[0]     = sum_valid_reg;
    assign cell_data[0].rem  = '0;
    assign cell_data[0].root = '0;
    assign cell_data[0].rad  = sum_reg;

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_cell
        fpd_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    assign done     = cell_valid[SQRT_STAGES];
    assign distance = cell_data[SQRT_STAGES].root;

    assign root_sq     = (2*ROOT_W+1)'(distance) * (2*ROOT_W+1)'(distance);
    assign root_inc_sq = ((2*ROOT_W+1)'(distance) + 1'b1) * ((2*ROOT_W+1)'(distance) + 1'b1);

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (root_sq <= {1'b0, $past(sum_reg, SQRT_STAGES)}) &&
                 (root_inc_sq > {1'b0, $past(sum_reg, SQRT_STAGES)}))
        else $error("distance is not the floor square root of the sum");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, SQRT_STAGES + 3))
        else $error("result strobe without an accepted beat");

    a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> mag_valid_reg)
        else $error("accepted beat lost at pipeline entry");

endmodule

/* sim/fixed_point_3d_distance_core_test.sv */
`timescale 1ns / 100ps

module fixed_point_3d_distance_core_test;

    typedef logic signed [fpd_pkg::COORD_W-1:0] coord_t;
    typedef logic [fpd_pkg::ROOT_W-1:0] dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } position_t;

    localparam int RANDOM_BEATS = 850;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_LIMIT = 50;

    class distance_scoreboard;
        dist_t pending[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        static function logic [16:0] axis_span(coord_t p, coord_t q);
            logic [31:0]        diff;
            logic signed [15:0] whole;
            logic signed [16:0] wide;
            diff  = p - q;
            whole = diff[31:16];
            wide  = whole;
            if (wide < 0)
                wide = -wide;
            return wide;
        endfunction

        static function dist_t floor_distance(position_t a, position_t b);
            logic [16:0] mx;
            logic [16:0] my;
            logic [16:0] mz;
            logic [31:0] sum_sq;
            logic [63:0] trial;
            dist_t       root;
            mx = axis_span(a.x, b.x);
            my = axis_span(a.y, b.y);
            mz = axis_span(a.z, b.z);
            sum_sq = 32'(mx) * 32'(mx) + 32'(my) * 32'(my) + 32'(mz) * 32'(mz);
            root = '0;
            for (int i = fpd_pkg::ROOT_W - 1; i >= 0; i--)
            begin
                trial = 64'(root | (dist_t'(1) << i));
                if (trial * trial <= 64'(sum_sq))
                    root = root | (dist_t'(1) << i);
            end
            return root;
        endfunction

        function void note_beat(position_t a, position_t b);
            pending.push_back(floor_distance(a, b));
        endfunction

        function void check_distance(dist_t got);
            dist_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: distance %0d arrived with none outstanding", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want, got);
            end
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    coord_t first_x = '0;
    coord_t first_y = '0;
    coord_t first_z = '0;
    coord_t second_x = '0;
    coord_t second_y = '0;
    coord_t second_z = '0;
    logic   done;
    dist_t  distance;

    distance_scoreboard board = new();
    int stall_cycles = 0;

    fixed_point_3d_distance_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .done     (done),
        .distance (distance)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Values are read in the active region of the edge, so they are those in force before it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_beat('{first_x, first_y, first_z}, '{second_x, second_y, second_z});
            if (done)
                board.check_distance(distance);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic position_t place(int dx, int dy, int dz);
        return '{coord_t'(dx) <<< 16, coord_t'(dy) <<< 16, coord_t'(dz) <<< 16};
    endfunction

    function automatic coord_t corner_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            3: return 32'shFFFFFFFF;
            4: return 32'sh0000FFFF;
            5: return 32'sh00010000;
            6: return 32'sh7FFF0000;
            default: return 32'sh80010000;
        endcase
    endfunction

    function automatic coord_t nearby(coord_t c);
        return c + coord_t'($urandom_range(0, 33554431)) - coord_t'(16777216);
    endfunction

    task automatic send_pair(input position_t a, input position_t b, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        first_x  <= a.x;
        first_y  <= a.y;
        first_z  <= a.z;
        second_x <= b.x;
        second_y <= b.y;
        second_z <= b.z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input int idle_pct);
        position_t a;
        position_t b;
        int        kind;
        kind = $urandom_range(0, 99);
        if (kind < 40)
        begin
            a = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
            b = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
        end
        else if (kind < 80)
        begin
            a = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
            b = '{nearby(a.x), nearby(a.y), nearby(a.z)};
        end
        else
        begin
            a = '{corner_coord(), corner_coord(), corner_coord()};
            b = '{corner_coord(), corner_coord(), corner_coord()};
        end
        send_pair(a, b, idle_pct);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(place(0, 0, 0), place(0, 0, 0), 10);
        send_pair('{3{32'sh7FFFFFFF}}, '{3{32'sh80000000}}, 10);
        send_pair('{3{32'sh80000000}}, '{3{32'sh7FFFFFFF}}, 10);
        send_pair('{3{32'sh80000000}}, place(0, 0, 0), 10);
        send_pair(place(32767, 32767, 32767), place(0, 0, 0), 10);
        send_pair('{3{32'sh0000FFFF}}, place(0, 0, 0), 10);
        send_pair(place(0, 0, 0), '{3{32'sh00000001}}, 10);
        send_pair('{3{32'shFFFFFFFF}}, place(0, 0, 0), 10);
        send_pair(place(3, 4, 0), place(0, 0, 0), 10);
        send_pair(place(0, 0, 0), place(3, 4, 0), 10);
        send_pair(place(2, 2, 2), place(0, 0, 0), 10);
        send_pair(place(4, 0, 0), place(0, 0, 0), 10);
        send_pair(place(3, 2, 1), place(0, 0, 0), 10);
        send_pair(place(-1, -2, -3), place(0, 0, 0), 10);
        send_pair('{32'sh80000000, 32'sh0, 32'sh0}, place(1, 0, 0), 10);
        send_pair(place(-32768, 0, 0), place(0, 0, 0), 10);
        send_pair(place(0, -32768, 0), place(0, 0, 0), 10);
        send_pair(place(0, 0, -32768), place(0, 0, 0), 10);
        send_pair('{3{32'shAAAAAAAA}}, '{3{32'sh55555555}}, 10);
        send_pair('{3{32'sh55555555}}, '{3{32'shAAAAAAAA}}, 10);
        send_pair(place(100, -200, 300), place(-100, 200, -300), 10);

        // The sender is paced in three stretches: light idling, heavy idling, none at all.
        for (int n = 0; n < RANDOM_BEATS / 3; n++)
            send_random(10);
        for (int n = 0; n < RANDOM_BEATS / 3; n++)
            send_random(53);
        for (int n = 0; n < RANDOM_BEATS - 2 * (RANDOM_BEATS / 3); n++)
            send_random(0);

        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* fixed_point_3d_distance_core.f */
rtl/fpd_pkg.sv
rtl/fpd_axis.sv
rtl/fpd_sqrt_cell.sv
rtl/fixed_point_3d_distance_core.sv
sim/fixed_point_3d_distance_core_test.sv
